>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the serial frame receiver
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define SFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// next-cycle implication, off while in reset
`define SFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

// next-cycle implication, always on (reset behavior)
`define SFR_ASSERT_NXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

>>> rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// types, codes and helper functions of the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

    typedef logic [7:0] t_byte;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MARKER  = 3'd0;
    localparam t_cfg_idx CFG_SYNC    = 3'd1;
    localparam t_cfg_idx CFG_CONNECT = 3'd2;
    localparam t_cfg_idx CFG_PING    = 3'd3;
    localparam t_cfg_idx CFG_PONG    = 3'd4;

    // configuration reset values
    localparam t_byte RST_MARKER  = 8'd126;
    localparam t_byte RST_SYNC    = 8'd1;
    localparam t_byte RST_CONNECT = 8'd2;
    localparam t_byte RST_PING    = 8'd3;
    localparam t_byte RST_PONG    = 8'd4;

    // action queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        K_DATA     = 3'd0,
        K_COMMIT   = 3'd1,
        K_BAD      = 3'd2,
        K_CONSUMED = 3'd3,
        K_TX       = 3'd4,
        K_LINKUP   = 3'd5,
        K_LINKDOWN = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_BODY  = 3'd3,
        PH_CRCLO = 3'd4,
        PH_CRCHI = 3'd5,
        PH_END   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        LK_IDLE = 2'd0,
        LK_WAIT = 2'd1,
        LK_UP   = 2'd2
    } t_link;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_UP   = 2'd1,
        EV_DOWN = 2'd2
    } t_evt;

    typedef struct packed {
        t_byte marker;
        t_byte sync_code;
        t_byte connect_code;
        t_byte ping_code;
        t_byte pong_code;
    } t_cfg;

    // one queued action: a payload byte or a frame end with its follow-ups
    typedef struct packed {
        logic  is_data;
        t_byte data;
        t_kind verdict;
        t_byte command;
        t_byte length;
        logic  reply;
        t_byte reply_code;
        t_byte marker;
        t_evt  evt;
    } t_act;

    typedef struct packed {
        t_kind kind;
        t_byte value;
        t_byte command;
        t_byte length;
        logic  last;
    } t_res;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    // crc-16/arc, reflected, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input t_byte b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// valid/ready channel interfaces of the serial frame receiver
// ----------------------------------------------------------------------------
interface sfr_byte_if;
    logic          valid;
    logic          ready;
    sfr_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_res_if;
    logic           valid;
    logic           ready;
    logic [2:0]     kind;
    sfr_pkg::t_byte value;
    sfr_pkg::t_byte command;
    sfr_pkg::t_byte length;
    logic           last;

    modport source (output valid, output kind, output value, output command,
                    output length, output last, input ready);
    modport sink   (input valid, input kind, input value, input command,
                    input length, input last, output ready);
endinterface

interface sfr_cfg_if;
    logic              valid;
    logic              ready;
    sfr_pkg::t_cfg_idx index;
    sfr_pkg::t_byte    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// frame parser and link handshake; turns bytes into queued actions
// ----------------------------------------------------------------------------
module sfr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sfr_pkg::t_byte i_byte,
    input  sfr_pkg::t_cfg  i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output sfr_pkg::t_act  o_act
);

    sfr_pkg::t_phase r_phase, n_phase;
    sfr_pkg::t_link  r_link, n_link;
    sfr_pkg::t_byte  r_cmd, n_cmd;
    sfr_pkg::t_byte  r_len, n_len;
    sfr_pkg::t_byte  r_left, n_left;
    logic [15:0]     r_crc, n_crc;
    logic [15:0]     r_rcrc, n_rcrc;

    logic accept;
    logic good;
    logic is_sync, is_conn, is_ping;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign good    = (r_crc == r_rcrc) && (i_byte == i_cfg.marker);
    assign is_sync = (r_cmd == i_cfg.sync_code);
    assign is_conn = (r_cmd == i_cfg.connect_code);
    assign is_ping = (r_cmd == i_cfg.ping_code);

    // next state: receive phase and link state
    always_comb begin
        n_phase = r_phase;
        n_link  = r_link;
        if (accept) begin
            case (r_phase)
                sfr_pkg::PH_CMD: begin
                    n_phase = sfr_pkg::PH_LEN;
                end
                sfr_pkg::PH_LEN: begin
                    n_phase = (i_byte == 8'd0) ? sfr_pkg::PH_CRCLO : sfr_pkg::PH_BODY;
                end
                sfr_pkg::PH_BODY: begin
                    if (r_left == 8'd1) begin
                        n_phase = sfr_pkg::PH_CRCLO;
                    end
                end
                sfr_pkg::PH_CRCLO: begin
                    n_phase = sfr_pkg::PH_CRCHI;
                end
                sfr_pkg::PH_CRCHI: begin
                    n_phase = sfr_pkg::PH_END;
                end
                sfr_pkg::PH_END: begin
                    n_phase = sfr_pkg::PH_HUNT;
                    if (!good) begin
                        n_link = sfr_pkg::LK_IDLE;
                    end else begin
                        case (r_link)
                            sfr_pkg::LK_IDLE: begin
                                if (is_sync) begin
                                    n_link = sfr_pkg::LK_WAIT;
                                end
                            end
                            sfr_pkg::LK_WAIT: begin
                                n_link = is_conn ? sfr_pkg::LK_UP : sfr_pkg::LK_IDLE;
                            end
                            default: begin
                                n_link = r_link;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = (i_byte == i_cfg.marker) ? sfr_pkg::PH_CMD : sfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // outputs: frame fields, crc and the queued action
    always_comb begin
        n_cmd  = r_cmd;
        n_len  = r_len;
        n_left = r_left;
        n_crc  = r_crc;
        n_rcrc = r_rcrc;
        o_push = 1'b0;
        o_act  = '0;
        o_act.command = r_cmd;
        o_act.length  = r_len;
        o_act.marker  = i_cfg.marker;
        o_act.verdict = sfr_pkg::K_CONSUMED;
        o_act.evt     = sfr_pkg::EV_NONE;
        if (accept) begin
            case (r_phase)
                sfr_pkg::PH_CMD: begin
                    n_cmd = i_byte;
                end
                sfr_pkg::PH_LEN: begin
                    n_len  = i_byte;
                    n_left = i_byte;
                    n_crc  = 16'h0000;
                end
                sfr_pkg::PH_BODY: begin
                    o_push        = 1'b1;
                    o_act.is_data = 1'b1;
                    o_act.data    = i_byte;
                    n_crc  = sfr_pkg::crc_byte(r_crc, i_byte);
                    n_left = r_left - 8'd1;
                end
                sfr_pkg::PH_CRCLO: begin
                    n_rcrc = {8'h00, i_byte};
                end
                sfr_pkg::PH_CRCHI: begin
                    n_rcrc = {i_byte, r_rcrc[7:0]};
                end
                sfr_pkg::PH_END: begin
                    o_push = 1'b1;
                    if (!good) begin
                        o_act.verdict = sfr_pkg::K_BAD;
                        if (r_link == sfr_pkg::LK_UP) begin
                            o_act.evt = sfr_pkg::EV_DOWN;
                        end
                    end else begin
                        case (r_link)
                            sfr_pkg::LK_IDLE: begin
                                o_act.reply      = is_sync;
                                o_act.reply_code = i_cfg.sync_code;
                            end
                            sfr_pkg::LK_WAIT: begin
                                o_act.reply      = is_conn;
                                o_act.reply_code = i_cfg.connect_code;
                                o_act.evt        = is_conn ? sfr_pkg::EV_UP : sfr_pkg::EV_NONE;
                            end
                            default: begin
                                o_act.verdict    = is_ping ? sfr_pkg::K_CONSUMED
                                                           : sfr_pkg::K_COMMIT;
                                o_act.reply      = is_ping;
                                o_act.reply_code = i_cfg.pong_code;
                            end
                        endcase
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfr_pkg::PH_HUNT;
            r_link  <= sfr_pkg::LK_IDLE;
            r_cmd   <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_crc   <= '0;
            r_rcrc  <= '0;
        end else begin
            r_phase <= n_phase;
            r_link  <= n_link;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_left  <= n_left;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
        end
    end

endmodule

>>> rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// short action queue between parser and result sequencer
// ----------------------------------------------------------------------------
module sfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_act i_act,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sfr_pkg::t_act o_head
);

    sfr_pkg::t_act             r_mem [sfr_pkg::QDEPTH];
    logic [sfr_pkg::QAW-1:0]   r_wr, n_wr;
    logic [sfr_pkg::QAW-1:0]   r_rd, n_rd;
    logic [sfr_pkg::QAW:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (sfr_pkg::QAW+1)'(sfr_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// expands queued actions into result transactions, one per cycle unless stalled
// ----------------------------------------------------------------------------
module sfr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sfr_pkg::t_act i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output sfr_pkg::t_res o_res
);

    sfr_pkg::t_act r_cur, n_cur;
    logic          r_busy, n_busy;
    logic [2:0]    r_step, n_step;
    logic          r_valid, n_valid;
    sfr_pkg::t_res r_out, n_out;

    sfr_pkg::t_act sel;
    logic [2:0]    step;
    logic [2:0]    last_idx;
    logic          slot_free;
    logic          have;
    sfr_pkg::t_res res;

    assign slot_free = !r_valid || i_ready;
    assign have      = r_busy || !i_empty;
    assign sel       = r_busy ? r_cur : i_head;
    assign step      = r_busy ? r_step : 3'd0;
    assign o_pop     = slot_free && !r_busy && !i_empty;

    // index of the final result of the selected action
    always_comb begin
        last_idx = 3'd0;
        if (!sel.is_data) begin
            last_idx = (sel.reply ? 3'd6 : 3'd0)
                     + ((sel.evt != sfr_pkg::EV_NONE) ? 3'd1 : 3'd0);
        end
    end

    // result for the selected step
    always_comb begin
        res      = '0;
        res.last = (step == last_idx);
        if (sel.is_data) begin
            res.kind  = sfr_pkg::K_DATA;
            res.value = sel.data;
        end else if (step == 3'd0) begin
            res.kind    = sel.verdict;
            res.command = sel.command;
            res.length  = sel.length;
        end else if (sel.reply && step <= 3'd6) begin
            res.kind = sfr_pkg::K_TX;
            case (step)
                3'd1:    res.value = sel.marker;
                3'd2:    res.value = sel.reply_code;
                3'd6:    res.value = sel.marker;
                default: res.value = 8'd0;
            endcase
        end else begin
            res.kind = (sel.evt == sfr_pkg::EV_UP) ? sfr_pkg::K_LINKUP : sfr_pkg::K_LINKDOWN;
        end
    end

    always_comb begin
        n_cur   = r_cur;
        n_busy  = r_busy;
        n_step  = r_step;
        n_valid = r_valid;
        n_out   = r_out;
        if (slot_free) begin
            n_valid = have;
            if (have) begin
                n_out = res;
                if (res.last) begin
                    n_busy = 1'b0;
                end else begin
                    n_busy = 1'b1;
                    n_cur  = sel;
                    n_step = step + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

endmodule

>>> rtl/serial_frame_receiver_handshake.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_handshake
// framed serial receiver with crc-16/arc check and link handshake
// ----------------------------------------------------------------------------
// i_rx carries received bytes, one per transaction; o_res carries results
// (payload byte, commit, bad frame, consumed, tx byte, link up, link down),
// with last set on the final result caused by one received byte.
// i_cfg writes the marker and command code registers; it is always ready,
// and the user must see it is only written while the block is idle (not
// enforced by the block). a byte is taken every cycle while the action queue
// has room, so input throughput is one byte per clock. an accepted byte's
// action is queued, then its first result goes into the output register.
// a frame end expands into up to 8 results, sent one per cycle by the
// sequencer unless stalled; the 4-entry queue absorbs them, and once it
// fills i_rx.ready drops until results drain. when o_res.ready is low the
// output register holds its transaction and the queue fills behind it.
// reset is synchronous: parser back to hunting, link idle, queue empty,
// output invalid, configuration back to its defaults.
// ----------------------------------------------------------------------------
module serial_frame_receiver_handshake (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfr_byte_if.sink  i_rx,
    sfr_res_if.source o_res,
    sfr_cfg_if.sink   i_cfg
);

    sfr_pkg::t_cfg r_cfg, n_cfg;

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    sfr_pkg::t_act act;
    sfr_pkg::t_act head;
    sfr_pkg::t_res res;

    // configuration registers, written by index
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                sfr_pkg::CFG_MARKER:  n_cfg.marker       = i_cfg.data;
                sfr_pkg::CFG_SYNC:    n_cfg.sync_code    = i_cfg.data;
                sfr_pkg::CFG_CONNECT: n_cfg.connect_code = i_cfg.data;
                sfr_pkg::CFG_PING:    n_cfg.ping_code    = i_cfg.data;
                sfr_pkg::CFG_PONG:    n_cfg.pong_code    = i_cfg.data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker       <= sfr_pkg::RST_MARKER;
            r_cfg.sync_code    <= sfr_pkg::RST_SYNC;
            r_cfg.connect_code <= sfr_pkg::RST_CONNECT;
            r_cfg.ping_code    <= sfr_pkg::RST_PING;
            r_cfg.pong_code    <= sfr_pkg::RST_PONG;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: parse bytes, run the link handshake, emit actions
    sfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .o_ready (i_rx.ready),
        .i_byte  (i_rx.rx_byte),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_act   (act)
    );

    // decoupling queue
    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_act   (act),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // back: expand each action into its result transactions
    sfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    assign o_res.kind    = res.kind;
    assign o_res.value   = res.value;
    assign o_res.command = res.command;
    assign o_res.length  = res.length;
    assign o_res.last    = res.last;

endmodule

>>> rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// port-level checks of the serial frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_kind,
    input logic [7:0] i_value,
    input logic [7:0] i_command,
    input logic [7:0] i_length,
    input logic       i_last
);

    // a stalled result holds
    `SFR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_kind) && $stable(i_value) && $stable(i_last))

    // reset empties the output
    `SFR_ASSERT_NXT_NORST(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)

    // payload bytes and link events always close their byte's results
    `SFR_ASSERT_IMP(a_single_last, i_clk, i_rst_n,
        i_out_valid && (i_kind == sfr_pkg::K_DATA || i_kind == sfr_pkg::K_LINKUP
                        || i_kind == sfr_pkg::K_LINKDOWN),
        i_last)

    // only verdicts carry command and length
    `SFR_ASSERT_IMP(a_verdict_fields, i_clk, i_rst_n,
        i_out_valid && i_kind != sfr_pkg::K_COMMIT && i_kind != sfr_pkg::K_BAD
                    && i_kind != sfr_pkg::K_CONSUMED,
        i_command == 8'd0 && i_length == 8'd0)

endmodule

bind serial_frame_receiver_handshake sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_value     (o_res.value),
    .i_command   (o_res.command),
    .i_length    (o_res.length),
    .i_last      (o_res.last)
);

>>> tb/sv/serial_frame_receiver_handshake_tb.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_handshake_tb
// self-checking bench for the framed serial receiver and its link handshake
// ----------------------------------------------------------------------------
// feeds framed byte streams (good, corrupted, truncated and noise) through
// the receive channel. a cycle-free model of the parser and the link state
// machine predicts every result transaction, which is checked in order.
// both sides insert random gaps; the marker and command code registers
// are rewritten between phases while the block is quiet.
// ----------------------------------------------------------------------------
module serial_frame_receiver_handshake_tb;
    import sfr_pkg::*;

    // one directed frame: leading noise, header, corruption, pinned verdict
    typedef struct packed {
        logic [1:0] noise;
        t_byte      cmd;
        t_byte      len;
        logic       crc_bad;
        logic       end_bad;
        logic       pin;
        t_kind      verdict;
    } t_frame_row;

    logic i_clk;
    logic i_rst_n;

    sfr_byte_if rx_ch ();
    sfr_res_if  res_ch ();
    sfr_cfg_if  cfg_ch ();

    serial_frame_receiver_handshake dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state: parser, link and register copies
    t_cfg        regs;
    t_phase      parse_ph;
    t_link       link_st;
    t_byte       cur_cmd;
    t_byte       cur_len;
    t_byte       body_left;
    logic [15:0] body_crc;
    logic [15:0] sent_crc;

    // results caused by the byte in flight, then all results still owed
    t_res step_out[$];
    t_res due_results[$];

    int   items_fed;
    int   fail_count;
    bit   src_gap_on;
    bit   sink_gap_on;
    int   sink_hold;
    t_res want_res;

    // handshake sequences; pinned verdicts are the ones obvious from the row
    // order: idle with a foreign command, and both kinds of corruption
    t_frame_row directed_frames [0:8] = '{
        '{2'd2, 8'h00,       8'd0, 1'b0, 1'b0, 1'b1, K_CONSUMED}, // idle, not sync
        '{2'd0, RST_SYNC,    8'd0, 1'b0, 1'b0, 1'b0, K_CONSUMED}, // sync echo
        '{2'd0, 8'hFF,       8'd1, 1'b0, 1'b0, 1'b0, K_CONSUMED}, // wrong cmd in wait
        '{2'd0, RST_SYNC,    8'd1, 1'b0, 1'b0, 1'b0, K_CONSUMED},
        '{2'd0, RST_CONNECT, 8'd0, 1'b0, 1'b0, 1'b0, K_CONSUMED}, // link up
        '{2'd0, RST_PING,    8'd2, 1'b0, 1'b0, 1'b0, K_CONSUMED}, // pong
        '{2'd0, 8'h5A,       8'd3, 1'b0, 1'b0, 1'b0, K_COMMIT},
        '{2'd0, RST_PING,    8'd1, 1'b1, 1'b0, 1'b1, K_BAD},      // crc error, link down
        '{2'd1, RST_SYNC,    8'd0, 1'b0, 1'b1, 1'b1, K_BAD}       // wrong end byte
    };

    // clock, 20 time units
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // reflected crc-16 with polynomial 0xa001, one byte
    function automatic logic [15:0] crc_arc_step(input logic [15:0] crc, input t_byte b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic void emit(input t_kind k, input t_byte v, input t_byte c,
                                 input t_byte l);
        step_out.push_back(t_res'{k, v, c, l, 1'b0});
    endfunction

    // six-byte reply frame with empty payload
    function automatic void emit_reply(input t_byte code);
        emit(K_TX, regs.marker, 8'h00, 8'h00);
        emit(K_TX, code, 8'h00, 8'h00);
        repeat (3) emit(K_TX, 8'h00, 8'h00, 8'h00);
        emit(K_TX, regs.marker, 8'h00, 8'h00);
    endfunction

    // advance the parser by one received byte and queue what it causes;
    // a pinned verdict replaces the computed verdict kind
    function automatic void parse_rx_byte(input t_byte b, input bit pin, input t_kind pinned);
        step_out.delete();
        case (parse_ph)
            PH_CMD: begin
                cur_cmd  = b;
                parse_ph = PH_LEN;
            end
            PH_LEN: begin
                cur_len   = b;
                body_left = b;
                body_crc  = 16'h0000;
                parse_ph  = (b == 8'h00) ? PH_CRCLO : PH_BODY;
            end
            PH_BODY: begin
                emit(K_DATA, b, 8'h00, 8'h00);
                body_crc  = crc_arc_step(body_crc, b);
                body_left = body_left - 8'd1;
                if (body_left == 8'h00) parse_ph = PH_CRCLO;
            end
            PH_CRCLO: begin
                sent_crc = {8'h00, b};
                parse_ph = PH_CRCHI;
            end
            PH_CRCHI: begin
                sent_crc[15:8] = b;
                parse_ph       = PH_END;
            end
            PH_END: begin
                if (body_crc != sent_crc || b != regs.marker) begin
                    emit(K_BAD, 8'h00, cur_cmd, cur_len);
                    if (link_st == LK_UP) emit(K_LINKDOWN, 8'h00, 8'h00, 8'h00);
                    link_st = LK_IDLE;
                end else if (link_st == LK_IDLE) begin
                    emit(K_CONSUMED, 8'h00, cur_cmd, cur_len);
                    if (cur_cmd == regs.sync_code) begin
                        emit_reply(regs.sync_code);
                        link_st = LK_WAIT;
                    end
                end else if (link_st == LK_WAIT) begin
                    emit(K_CONSUMED, 8'h00, cur_cmd, cur_len);
                    if (cur_cmd == regs.connect_code) begin
                        emit_reply(regs.connect_code);
                        emit(K_LINKUP, 8'h00, 8'h00, 8'h00);
                        link_st = LK_UP;
                    end else begin
                        link_st = LK_IDLE;
                    end
                end else if (cur_cmd == regs.ping_code) begin
                    emit(K_CONSUMED, 8'h00, cur_cmd, cur_len);
                    emit_reply(regs.pong_code);
                end else begin
                    emit(K_COMMIT, 8'h00, cur_cmd, cur_len);
                end
                parse_ph = PH_HUNT;
            end
            // hunting, and unused codes behave the same
            default: parse_ph = (b == regs.marker) ? PH_CMD : PH_HUNT;
        endcase
        if (pin && step_out.size() > 0) step_out[0].kind = pinned;
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) due_results.push_back(step_out[i]);
    endfunction

    // one receive transaction; valid stays up if the next byte follows at once
    task automatic send_rx_byte(input t_byte b, input bit pin = 1'b0,
                                input t_kind pinned = K_DATA);
        int gap;
        gap = src_gap_on ? $urandom_range(0, 13) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            rx_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        // bytes dropped while hunting do not count
        if (parse_ph != PH_HUNT || b == regs.marker) items_fed++;
        parse_rx_byte(b, pin, pinned);
    endtask

    task automatic send_frame(input t_byte cmd, input t_byte len, input bit crc_bad,
                              input bit end_bad, input bit pin = 1'b0,
                              input t_kind pinned = K_DATA);
        logic [15:0] crc;
        t_byte       pay;
        t_byte       end_byte;
        int          i;
        crc = 16'h0000;
        send_rx_byte(regs.marker);
        send_rx_byte(cmd);
        send_rx_byte(len);
        for (i = 0; i < len; i++) begin
            pay = t_byte'($urandom_range(0, 255));
            crc = crc_arc_step(crc, pay);
            send_rx_byte(pay);
        end
        if (crc_bad) crc = crc ^ 16'($urandom_range(1, 65535));
        send_rx_byte(crc[7:0]);
        send_rx_byte(crc[15:8]);
        end_byte = end_bad ? (regs.marker ^ t_byte'($urandom_range(1, 255))) : regs.marker;
        send_rx_byte(end_byte, pin, pinned);
    endtask

    // finish any half-sent frame with short filler
    task automatic flush_to_hunt();
        while (parse_ph != PH_HUNT)
            send_rx_byte((parse_ph == PH_LEN) ? 8'h00 : t_byte'($urandom_range(0, 255)));
    endtask

    // drop valid, wait for every owed result, then let the pipeline go quiet
    task automatic settle();
        flush_to_hunt();
        @(negedge i_clk);
        rx_ch.valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_byte v);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = v;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_MARKER:  regs.marker       = v;
            CFG_SYNC:    regs.sync_code    = v;
            CFG_CONNECT: regs.connect_code = v;
            CFG_PING:    regs.ping_code    = v;
            CFG_PONG:    regs.pong_code    = v;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all_regs(input t_byte m, input t_byte s, input t_byte c,
                                  input t_byte p, input t_byte q);
        write_reg(CFG_MARKER, m);
        write_reg(CFG_SYNC, s);
        write_reg(CFG_CONNECT, c);
        write_reg(CFG_PING, p);
        write_reg(CFG_PONG, q);
    endtask

    // mostly handshake-driven frames with random content, some noise,
    // truncated frames and corrupted ones
    task automatic random_traffic(input int count);
        int    start;
        int    roll;
        t_byte cmd;
        t_byte len;
        start = items_fed;
        while (items_fed - start < count) begin
            if ($urandom_range(0, 39) == 0) begin
                src_gap_on  = $urandom_range(0, 1);
                sink_gap_on = $urandom_range(0, 1);
            end
            flush_to_hunt();
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                repeat ($urandom_range(1, 3)) send_rx_byte(t_byte'($urandom_range(0, 255)));
            end else if (roll < 12) begin
                // start marker and command, then the frame is cut short
                send_rx_byte(regs.marker);
                send_rx_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                roll = $urandom_range(0, 99);
                cmd  = t_byte'($urandom_range(0, 255));
                case (link_st)
                    LK_IDLE: if (roll < 65) cmd = regs.sync_code;
                    LK_WAIT: if (roll < 70) cmd = regs.connect_code;
                    default: if (roll < 35) cmd = regs.ping_code;
                endcase
                len = ($urandom_range(0, 19) == 0) ? t_byte'($urandom_range(7, 24))
                                                   : t_byte'($urandom_range(0, 6));
                send_frame(cmd, len, $urandom_range(0, 15) == 0, $urandom_range(0, 19) == 0);
            end
        end
    endtask

    // result sink: random or long stall before each transaction
    initial begin
        int wait_cycles;
        res_ch.ready = 1'b0;
        forever begin
            if (sink_hold > 0) begin
                wait_cycles = sink_hold;
                sink_hold   = 0;
            end else begin
                wait_cycles = sink_gap_on ? $urandom_range(0, 13) : 0;
            end
            repeat (wait_cycles) begin
                @(negedge i_clk);
                res_ch.ready = 1'b0;
            end
            @(negedge i_clk);
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    // result checker: every accepted transaction against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d value=%h command=%h length=%h last=%b",
                         $time, res_ch.kind, res_ch.value, res_ch.command, res_ch.length,
                         res_ch.last);
                fail_count++;
            end else begin
                want_res = due_results.pop_front();
                if (res_ch.kind !== want_res.kind || res_ch.value !== want_res.value ||
                    res_ch.command !== want_res.command ||
                    res_ch.length !== want_res.length || res_ch.last !== want_res.last) begin
                    $display("%0t: expected kind=%0d value=%h command=%h length=%h last=%b",
                             $time, want_res.kind, want_res.value, want_res.command,
                             want_res.length, want_res.last);
                    $display("%0t: actual   kind=%0d value=%h command=%h length=%h last=%b",
                             $time, res_ch.kind, res_ch.value, res_ch.command,
                             res_ch.length, res_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int r;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_MARKER;
        cfg_ch.data   = 8'h00;
        regs          = '{RST_MARKER, RST_SYNC, RST_CONNECT, RST_PING, RST_PONG};
        parse_ph      = PH_HUNT;
        link_st       = LK_IDLE;
        cur_cmd       = 8'h00;
        cur_len       = 8'h00;
        body_left     = 8'h00;
        body_crc      = 16'h0000;
        sent_crc      = 16'h0000;
        items_fed     = 0;
        fail_count    = 0;
        src_gap_on    = 1'b1;
        sink_gap_on   = 1'b1;
        sink_hold     = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed frames under reset register values
        foreach (directed_frames[i]) begin
            for (r = 0; r < directed_frames[i].noise; r++)
                send_rx_byte(r[0] ? 8'hFF : 8'h00);
            send_frame(directed_frames[i].cmd, directed_frames[i].len,
                       directed_frames[i].crc_bad, directed_frames[i].end_bad,
                       directed_frames[i].pin, directed_frames[i].verdict);
        end

        // long sink stall under a back-to-back burst: the action queue fills
        // and the receive channel must hold off
        sink_hold  = 150;
        src_gap_on = 1'b0;
        send_frame(regs.sync_code, 8'd0, 1'b0, 1'b0);
        send_frame(regs.connect_code, 8'd2, 1'b0, 1'b0);
        send_frame(regs.ping_code, 8'd0, 1'b0, 1'b0);
        send_frame(regs.ping_code, 8'd1, 1'b0, 1'b0);
        send_frame(8'h33, 8'd4, 1'b0, 1'b0);
        src_gap_on = 1'b1;

        random_traffic(35);
        settle();

        // low marker, high codes
        write_all_regs(8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF);
        random_traffic(35);
        settle();

        // high marker, low codes but a high connect code; sync and ping share a code
        write_all_regs(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
        random_traffic(35);
        settle();

        // random register values
        write_all_regs(t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                       t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                       t_byte'($urandom_range(0, 255)));
        random_traffic(35);
        settle();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
